/* hdl/blls_pkg.sv */
// Shared types and constants for the bounded LIFO stack.
package blls_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int DATA_W    = 32;
	localparam int POS_W     = 6;

	typedef enum logic [1:0] {
		ACT_PUSH = 2'd0,
		ACT_POP  = 2'd1,
		ACT_PEEK = 2'd2,
		ACT_DUMP = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	// Move applied by every storage cell at a clock edge.
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_DOWN = 2'd1,
		CELL_UP   = 2'd2
	} cell_op_t;

endpackage

/* hdl/blls_cell.sv */
// One storage cell of the stack chain: holds a word or takes a neighbor's.
module blls_cell
	import blls_pkg::*;
(
	input  logic                     clk,
	input  cell_op_t                 op,
	input  logic signed [DATA_W-1:0] prev_data,
	input  logic signed [DATA_W-1:0] next_data,
	output logic signed [DATA_W-1:0] data
);

	logic signed [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_DOWN: data_q <= prev_data;
			CELL_UP:   data_q <= next_data;
			default:   data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

/* hdl/bounded_lifo_stack.sv */
// Top level of the bounded LIFO stack: control, output register and cell chain.
//
// The stack lives in a chain of DEPTH cells with the top entry in cell 0: a push
// shifts every cell down one place and loads the new word into cell 0, a pop
// shifts every cell up one place. Push, pop and peek take one request per cycle,
// each giving one result that waits in an output register; the next request is
// taken once that register is empty or is read in the same cycle. A dump rotates
// the whole chain once around (cell 0 takes the last cell) whatever the fill
// level, and the rotation stalls while an entry waits on m_tready; the entries
// leave from the last cell bottom first during the final entry-count steps of
// that rotation, and the chain is back in place at the end, when the next
// request can be taken. A dump on an empty stack gives a single STAT_EMPTY
// result and no rotation. No request is taken while a dump runs. Status is on
// m_tuser, the final result of each request carries m_tlast.
module bounded_lifo_stack
	import blls_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [1:0]  s_tuser,   // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] data, [37:32] position, [39:38] zero
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int RW = $clog2(DEPTH);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
	localparam logic [CW:0]   DEPTH_W   = (CW + 1)'(DEPTH);
	localparam logic [RW-1:0] LAST_ROT  = RW'(DEPTH - 1);

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            count_q;
	logic [RW-1:0]            rot_q;
	logic                     m_valid_q;
	status_t                  m_status_q;
	logic signed [DATA_W-1:0] m_data_q;
	logic [POS_W-1:0]         m_pos_q;
	logic                     m_last_q;

	logic signed [DATA_W-1:0] cell_data [DEPTH];
	logic signed [DATA_W-1:0] chain_in;
	cell_op_t                 cell_op;

	logic       slot_free;
	logic       accept;
	action_t    act;
	logic       empty;
	logic       full;
	logic [CW:0] dump_sum;
	logic       dump_emit;
	logic       dump_step;
	logic [POS_W-1:0] dump_pos;
	logic       push_ok;
	logic       pop_ok;
	logic       dump_start;
	logic       load_res;
	status_t    res_status;
	logic signed [DATA_W-1:0] res_data;
	logic [POS_W-1:0] res_pos;
	logic       res_last;

	assign slot_free = !m_valid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE) && slot_free;
	assign accept    = s_tvalid && s_tready;
	assign act       = action_t'(s_tuser);
	assign empty     = (count_q == '0);
	assign full      = (count_q == FULL_CNT);

	// Rotation steps at or past DEPTH - count bring a stored entry to the last cell.
	assign dump_sum  = (CW + 1)'(rot_q) + (CW + 1)'(count_q);
	assign dump_emit = (dump_sum >= DEPTH_W);
	assign dump_pos  = POS_W'(dump_sum - DEPTH_W);
	assign dump_step = (state_q == S_DUMP) && (!dump_emit || slot_free);

	assign push_ok    = accept && (act == ACT_PUSH) && !full;
	assign pop_ok     = accept && (act == ACT_POP) && !empty;
	assign dump_start = accept && (act == ACT_DUMP) && !empty;
	assign load_res   = (accept && !dump_start) || (dump_step && dump_emit);

	always_comb begin
		cell_op  = CELL_HOLD;
		chain_in = cell_data[DEPTH-1];
		if (accept) begin
			unique case (act)
				ACT_PUSH: begin
					if (!full) begin
						cell_op  = CELL_DOWN;
						chain_in = $signed(s_tdata);
					end
				end
				ACT_POP: begin
					if (!empty) cell_op = CELL_UP;
				end
				ACT_PEEK: cell_op = CELL_HOLD;
				ACT_DUMP: cell_op = CELL_HOLD;
			endcase
		end else if (dump_step) begin
			cell_op = CELL_DOWN;
		end
	end

	// Result loaded into the output register, from a request or a dump step.
	always_comb begin
		res_status = STAT_OK;
		res_data   = '0;
		res_pos    = '0;
		res_last   = 1'b1;
		if (accept) begin
			unique case (act)
				ACT_PUSH: begin
					if (full) res_status = STAT_FULL;
				end
				ACT_POP: begin
					if (empty) res_status = STAT_EMPTY;
				end
				ACT_PEEK: begin
					if (empty) res_status = STAT_EMPTY;
					else res_data = cell_data[0];
				end
				ACT_DUMP: begin
					if (empty) res_status = STAT_EMPTY;
				end
			endcase
		end else begin
			res_data = cell_data[DEPTH-1];
			res_pos  = dump_pos;
			res_last = (rot_q == LAST_ROT);
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic signed [DATA_W-1:0] prev_w;
			logic signed [DATA_W-1:0] next_w;
			if (gi == 0) begin : g_first
				assign prev_w = chain_in;
			end else begin : g_mid_prev
				assign prev_w = cell_data[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_last
				assign next_w = cell_data[gi];
			end else begin : g_mid_next
				assign next_w = cell_data[gi+1];
			end
			blls_cell u_cell (
				.clk       (clk),
				.op        (cell_op),
				.prev_data (prev_w),
				.next_data (next_w),
				.data      (cell_data[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			rot_q      <= '0;
			m_valid_q  <= 1'b0;
			m_status_q <= STAT_OK;
			m_data_q   <= '0;
			m_pos_q    <= '0;
			m_last_q   <= 1'b0;
		end else begin
			if (load_res) begin
				m_valid_q  <= 1'b1;
				m_status_q <= res_status;
				m_data_q   <= res_data;
				m_pos_q    <= res_pos;
				m_last_q   <= res_last;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end

			if (push_ok) count_q <= count_q + CW'(1);
			else if (pop_ok) count_q <= count_q - CW'(1);

			if (dump_start) begin
				rot_q   <= '0;
				state_q <= S_DUMP;
			end else if (dump_step) begin
				rot_q <= rot_q + RW'(1);
				if (rot_q == LAST_ROT) state_q <= S_IDLE;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, m_pos_q, m_data_q};
	assign m_tuser  = m_status_q;
	assign m_tlast  = m_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above depth");

	a_no_req_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |-> !s_tready)
		else $error("request taken during dump");

	a_dump_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP && m_valid_q) |-> !m_last_q)
		else $error("final dump result while dump still running");

	a_fail_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_status_q != STAT_OK) |-> (m_data_q == '0 && m_pos_q == '0))
		else $error("failing status with nonzero payload");

	a_count_stable_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |=> $stable(count_q))
		else $error("entry count changed during dump");

endmodule
